### design/generational_slot_allocator_top_assert.svh
// ----------------------------------------------------------------------------
// generational slot allocator assertion macros
// concurrent checks clocked on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// condition that holds at every clock edge
`define GSA_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);
// condition that holds in the cycle after a trigger
`define GSA_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);
`else
`define GSA_ASSERT_ALWAYS(label, cond, msg)
`define GSA_ASSERT_NEXT(label, trig, cond, msg)
`endif
`endif

### design/gsa_pkg.sv
// ----------------------------------------------------------------------------
// gsa_pkg
// shared widths, codes and defaults of the generational slot allocator
// ----------------------------------------------------------------------------
package gsa_pkg;

    // field widths of the transactions
    localparam int OP_W     = 3;
    localparam int SLOT_W   = 10;
    localparam int GEN_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;
    localparam int CAP_W    = 11;

    // default table size and capacity register reset
    localparam int SLOTS_DEFAULT = 1024;
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ALLOC    = 3'd0,
        OP_RELEASE  = 3'd1,
        OP_ALIVE    = 3'd2,
        OP_READ_PH  = 3'd3,
        OP_WRITE_PH = 3'd4
    } t_opcode;

    // response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_STALE = 2'd2
    } t_status;

    // one table entry: alive bit, phantom bit, generation
    typedef struct packed {
        logic             alive;
        logic             phantom;
        logic [GEN_W-1:0] gen;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

### design/gsa_req_if.sv
// ----------------------------------------------------------------------------
// gsa_req_if
// request channel: valid/ready handshake with the operation payload
// ----------------------------------------------------------------------------
interface gsa_req_if;
    import gsa_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [SLOT_W-1:0] req_slot;
    logic [GEN_W-1:0]  req_generation;
    logic              phantom_value;

    modport source (
        output valid, opcode, req_slot, req_generation, phantom_value,
        input  ready
    );
    modport sink (
        input  valid, opcode, req_slot, req_generation, phantom_value,
        output ready
    );
endinterface

### design/gsa_rsp_if.sv
// ----------------------------------------------------------------------------
// gsa_rsp_if
// response channel: valid/ready handshake with the result payload
// ----------------------------------------------------------------------------
interface gsa_rsp_if;
    import gsa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   result_slot;
    logic [GEN_W-1:0]    result_generation;
    logic                phantom_flag;
    logic [COUNT_W-1:0]  live_total;

    modport source (
        output valid, status, result_slot, result_generation, phantom_flag, live_total,
        input  ready
    );
    modport sink (
        input  valid, status, result_slot, result_generation, phantom_flag, live_total,
        output ready
    );
endinterface

### design/gsa_ram.sv
// ----------------------------------------------------------------------------
// gsa_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module gsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### design/generational_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// generational_slot_allocator_top
// generational handle table with a lifo free-slot stack
//
//   channel   dir  handshake          contents
//   i_req     in   valid/ready        opcode, slot, generation, phantom value
//   o_rsp     out  valid/ready        status, slot, generation, flag, live total
//   i_cfg_*   in   write enable only  capacity limit (11 bits)
//
// a request is accepted in idle and its table entry is read for exec, which loads
// the output register; an allocate that pops the free stack passes the pop state
// first (stack read, then table read); a new request waits until the result loads
// sync active-low reset clears counters and control; entries at or above the
// high-water mark read as never used, so the table needs no clearing pass
// a stalled response holds the next transaction's table update until it frees
// ----------------------------------------------------------------------------
module generational_slot_allocator_top #(
    parameter int SLOTS = gsa_pkg::SLOTS_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    gsa_req_if.sink                  i_req,
    gsa_rsp_if.source                o_rsp,
    input  logic                     i_cfg_we,
    input  logic [gsa_pkg::CAP_W-1:0] i_cfg_wdata
);
    import gsa_pkg::*;

`include "generational_slot_allocator_top_assert.svh"

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {S_IDLE, S_POP, S_EXEC} t_state;

    // control state
    t_state              r_state, n_state;
    logic [CW-1:0]       r_free_depth, n_free_depth;
    logic [CW-1:0]       r_high_water, n_high_water;
    logic [CW-1:0]       r_alive_total, n_alive_total;
    logic [CAP_W-1:0]    r_cap, n_cap;
    logic                r_out_valid, n_out_valid;

    // request held during the operation
    logic [OP_W-1:0]     r_op, n_op;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [GEN_W-1:0]    r_gen, n_gen;
    logic                r_pval, n_pval;
    logic [IW-1:0]       r_idx, n_idx;
    logic                r_fresh, n_fresh;
    logic                r_full, n_full;

    // output register
    logic [STATUS_W-1:0] r_status, n_status;
    logic [SLOT_W-1:0]   r_rslot, n_rslot;
    logic [GEN_W-1:0]    r_rgen, n_rgen;
    logic                r_pflag, n_pflag;
    logic [COUNT_W-1:0]  r_live, n_live;

    // memory ports
    logic                tbl_we, tbl_re;
    logic [IW-1:0]       tbl_waddr, tbl_raddr;
    t_entry              tbl_wdata, tbl_rdata;
    logic                stk_we, stk_re;
    logic [IW-1:0]       stk_waddr, stk_raddr;
    logic [IW-1:0]       stk_wdata, stk_rdata;

    logic                accept, fire, hvalid;
    logic [GEN_W-1:0]    eff_cap, new_gen;

    // slot table: alive, phantom, generation per slot
    gsa_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_table (
        .i_clk  (i_clk),
        .i_we   (tbl_we),
        .i_waddr(tbl_waddr),
        .i_wdata(tbl_wdata),
        .i_re   (tbl_re),
        .i_raddr(tbl_raddr),
        .o_rdata(tbl_rdata)
    );

    // lifo of freed slot indexes
    gsa_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_stack (
        .i_clk  (i_clk),
        .i_we   (stk_we),
        .i_waddr(stk_waddr),
        .i_wdata(stk_wdata),
        .i_re   (stk_re),
        .i_raddr(stk_raddr),
        .o_rdata(stk_rdata)
    );

    // handshakes
    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && (r_state == S_IDLE);
    assign fire        = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);

    // effective cap: zero or above table size means the table size
    assign eff_cap = (r_cap == '0 || 32'(r_cap) > 32'(SLOTS)) ? 32'(SLOTS) : 32'(r_cap);

    // handle check against the entry read from the table
    assign hvalid = (r_gen != '0) && (32'(r_slot) < 32'(r_high_water))
                 && tbl_rdata.alive && (tbl_rdata.gen == r_gen);

    // never-used slots start at generation zero
    assign new_gen = (r_fresh ? '0 : tbl_rdata.gen) + GEN_W'(1);

    // next state, memory access and result
    always_comb begin
        n_state       = r_state;
        n_free_depth  = r_free_depth;
        n_high_water  = r_high_water;
        n_alive_total = r_alive_total;
        n_cap         = i_cfg_we ? i_cfg_wdata : r_cap;
        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_op          = r_op;
        n_slot        = r_slot;
        n_gen         = r_gen;
        n_pval        = r_pval;
        n_idx         = r_idx;
        n_fresh       = r_fresh;
        n_full        = r_full;
        n_status      = r_status;
        n_rslot       = r_rslot;
        n_rgen        = r_rgen;
        n_pflag       = r_pflag;
        n_live        = r_live;

        tbl_re    = 1'b0;
        tbl_raddr = IW'(i_req.req_slot);
        tbl_we    = 1'b0;
        tbl_waddr = r_idx;
        tbl_wdata = tbl_rdata;
        stk_re    = 1'b0;
        stk_raddr = IW'(r_free_depth - CW'(1));
        stk_we    = 1'b0;
        stk_waddr = IW'(r_free_depth);
        stk_wdata = IW'(r_slot);

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op    = i_req.opcode;
                    n_slot  = i_req.req_slot;
                    n_gen   = i_req.req_generation;
                    n_pval  = i_req.phantom_value;
                    n_idx   = IW'(i_req.req_slot);
                    n_fresh = 1'b0;
                    n_full  = 1'b0;
                    if (i_req.opcode == OP_ALLOC && r_free_depth != '0) begin
                        // pop: fetch the top of the free stack first
                        stk_re  = 1'b1;
                        n_state = S_POP;
                    end else begin
                        if (i_req.opcode == OP_ALLOC) begin
                            n_idx     = IW'(r_high_water);
                            tbl_raddr = IW'(r_high_water);
                            n_fresh   = (32'(r_high_water) < eff_cap);
                            n_full    = !(32'(r_high_water) < eff_cap);
                        end
                        tbl_re  = 1'b1;
                        n_state = S_EXEC;
                    end
                end
            end
            S_POP: begin
                n_idx     = stk_rdata;
                tbl_raddr = stk_rdata;
                tbl_re    = 1'b1;
                n_state   = S_EXEC;
            end
            S_EXEC: begin
                if (fire) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_STALE;
                    n_rslot     = r_slot;
                    n_rgen      = r_gen;
                    n_pflag     = 1'b0;
                    case (r_op)
                        OP_ALLOC: begin
                            if (r_full) begin
                                n_status = ST_FULL;
                                n_rslot  = '0;
                                n_rgen   = '0;
                            end else begin
                                tbl_we        = 1'b1;
                                tbl_wdata     = '{alive: 1'b1, phantom: 1'b0, gen: new_gen};
                                n_status      = ST_OK;
                                n_rslot       = SLOT_W'(r_idx);
                                n_rgen        = new_gen;
                                n_alive_total = r_alive_total + CW'(1);
                                if (r_fresh) begin
                                    n_high_water = r_high_water + CW'(1);
                                end else begin
                                    n_free_depth = r_free_depth - CW'(1);
                                end
                            end
                        end
                        OP_RELEASE: begin
                            if (hvalid) begin
                                n_status      = ST_OK;
                                n_pflag       = tbl_rdata.phantom;
                                tbl_we        = 1'b1;
                                tbl_wdata     = '{alive: 1'b0, phantom: tbl_rdata.phantom,
                                                  gen: tbl_rdata.gen};
                                if (32'(r_free_depth) < 32'(SLOTS)) begin
                                    stk_we       = 1'b1;
                                    n_free_depth = r_free_depth + CW'(1);
                                end
                                if (r_alive_total != '0) begin
                                    n_alive_total = r_alive_total - CW'(1);
                                end
                            end
                        end
                        OP_ALIVE, OP_READ_PH: begin
                            if (hvalid) begin
                                n_status = ST_OK;
                                n_pflag  = tbl_rdata.phantom;
                            end
                        end
                        OP_WRITE_PH: begin
                            if (hvalid) begin
                                n_status  = ST_OK;
                                n_pflag   = r_pval;
                                tbl_we    = 1'b1;
                                tbl_wdata = '{alive: 1'b1, phantom: r_pval, gen: tbl_rdata.gen};
                            end
                        end
                        default: begin
                            n_status = ST_STALE;
                        end
                    endcase
                    n_live  = COUNT_W'(n_alive_total);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state, counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_free_depth  <= '0;
            r_high_water  <= '0;
            r_alive_total <= '0;
            r_cap         <= CAP_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_free_depth  <= n_free_depth;
            r_high_water  <= n_high_water;
            r_alive_total <= n_alive_total;
            r_cap         <= n_cap;
            r_out_valid   <= n_out_valid;
            r_op          <= n_op;
            r_slot        <= n_slot;
            r_gen         <= n_gen;
            r_pval        <= n_pval;
            r_idx         <= n_idx;
            r_fresh       <= n_fresh;
            r_full        <= n_full;
            r_status      <= n_status;
            r_rslot       <= n_rslot;
            r_rgen        <= n_rgen;
            r_pflag       <= n_pflag;
            r_live        <= n_live;
        end
    end

    // response outputs
    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.status            = r_status;
    assign o_rsp.result_slot       = r_rslot;
    assign o_rsp.result_generation = r_rgen;
    assign o_rsp.phantom_flag      = r_pflag;
    assign o_rsp.live_total        = r_live;

    // every slot below the high-water mark is either alive or on the free stack
    `GSA_ASSERT_ALWAYS(a_slot_balance,
        32'(r_free_depth) + 32'(r_alive_total) == 32'(r_high_water),
        "free stack depth plus live count differs from high-water mark")
    // live count never passes the high-water mark
    `GSA_ASSERT_ALWAYS(a_live_bound, r_alive_total <= r_high_water,
        "live count above high-water mark")
    // an accepted transaction always leaves the idle state
    `GSA_ASSERT_NEXT(a_accept_busy, i_req.valid && i_req.ready, r_state != S_IDLE,
        "accepted transaction did not start an operation")
endmodule

### bench/tb_generational_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// tb_generational_slot_allocator_top
// self-checking bench for the generational slot allocator: a directed table
// (null, stale and unknown requests, the table-full case, lifo reuse, phantom
// flag handling, capacity register extremes), then four random phases that
// mix well-formed handles with stale and noisy ones under varied
// backpressure. every response is scored in order against the expected values
// of its directed row or against a software model of the handle table.
// ----------------------------------------------------------------------------
module tb_generational_slot_allocator_top;
    import gsa_pkg::*;

    localparam int SLOTS       = SLOTS_DEFAULT;
    localparam int PHASE_ITEMS = 175;
    localparam int CYCLE_LIMIT = 200000;

    // opcodes outside the defined set
    localparam logic [OP_W-1:0] OP_BAD_LO  = 3'd5;
    localparam logic [OP_W-1:0] OP_BAD_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_BAD_HI  = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [SLOT_W-1:0] slot;
        logic [GEN_W-1:0]  gen;
        logic              pval;
    } t_request;

    typedef struct packed {
        t_status            status;
        logic [SLOT_W-1:0]  slot;
        logic [GEN_W-1:0]   gen;
        logic               flag;
        logic [COUNT_W-1:0] live;
    } t_outcome;

    typedef struct {
        bit               is_cfg;
        logic [CAP_W-1:0] cap;
        t_request         rq;
        bit               typed;
        t_outcome         want;
    } t_dir_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_wdata;

    gsa_req_if req_ch ();
    gsa_rsp_if rsp_ch ();

    generational_slot_allocator_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // shadow copy of the handle table
    logic [GEN_W-1:0]  gen_table   [SLOTS];
    bit                alive_map   [SLOTS];
    bit                phantom_map [SLOTS];
    logic [SLOT_W-1:0] free_slots  [SLOTS];
    int                free_count;
    int                water_mark;
    int                live_count;
    logic [CAP_W-1:0]  cap_reg;

    t_outcome pending_results [$];
    t_dir_row dir_table [$];

    int mismatch_count = 0;
    int request_count  = 0;
    int alloc_total    = 0;
    int full_total     = 0;
    int stale_total    = 0;
    int cfg_writes     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d transactions outstanding",
                     $time, pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic bit handle_live(input logic [SLOT_W-1:0] slot,
                                       input logic [GEN_W-1:0] gen);
        if (gen == '0 || slot >= water_mark)
            return 1'b0;
        return alive_map[slot] && gen_table[slot] == gen;
    endfunction

    // apply one request to the shadow table and return its response
    function automatic t_outcome resolve_request(input t_request rq);
        t_outcome res;
        int idx;
        int cap;
        res.status = ST_OK;
        res.slot   = rq.slot;
        res.gen    = rq.gen;
        res.flag   = 1'b0;
        request_count++;
        if (rq.opcode == OP_ALLOC) begin
            cap = (cap_reg == '0 || cap_reg > SLOTS) ? SLOTS : int'(cap_reg);
            idx = -1;
            if (free_count > 0) begin
                free_count--;
                idx = free_slots[free_count];
            end else if (water_mark < cap) begin
                idx = water_mark;
                water_mark++;
            end
            if (idx >= 0) begin
                gen_table[idx]   = gen_table[idx] + 1;
                alive_map[idx]   = 1'b1;
                phantom_map[idx] = 1'b0;
                live_count++;
                res.slot = SLOT_W'(idx);
                res.gen  = gen_table[idx];
                alloc_total++;
            end else begin
                res.status = ST_FULL;
                res.slot   = '0;
                res.gen    = '0;
                full_total++;
            end
        end else if (rq.opcode <= OP_WRITE_PH) begin
            if (!handle_live(rq.slot, rq.gen)) begin
                res.status = ST_STALE;
            end else begin
                res.flag = phantom_map[rq.slot];
                if (rq.opcode == OP_RELEASE) begin
                    alive_map[rq.slot]     = 1'b0;
                    free_slots[free_count] = rq.slot;
                    free_count++;
                    live_count--;
                end else if (rq.opcode == OP_WRITE_PH) begin
                    phantom_map[rq.slot] = rq.pval;
                    res.flag             = rq.pval;
                end
            end
        end else begin
            res.status = ST_STALE;
        end
        if (res.status == ST_STALE)
            stale_total++;
        res.live = COUNT_W'(live_count);
        return res;
    endfunction

    // random alive slot below the high-water mark, or -1
    function automatic int find_live_slot();
        int start;
        int s;
        if (live_count == 0)
            return -1;
        start = $urandom_range(0, water_mark - 1);
        for (int k = 0; k < water_mark; k++) begin
            s = (start + k) % water_mark;
            if (alive_map[s])
                return s;
        end
        return -1;
    endfunction

    // mostly live handles, some damaged ones, some pure noise
    function automatic t_request random_request();
        t_request rq;
        int pick;
        int live_slot;
        rq.opcode = OP_ALLOC;
        rq.slot   = SLOT_W'($urandom_range(0, SLOTS - 1));
        rq.gen    = $urandom;
        rq.pval   = 1'($urandom_range(0, 1));
        pick      = $urandom_range(0, 99);
        if (pick < 35) begin
            rq.opcode = OP_ALLOC;
        end else if (pick < 93) begin
            rq.opcode = (pick < 58) ? OP_RELEASE :
                        (pick < 68) ? OP_ALIVE :
                        (pick < 79) ? OP_READ_PH : OP_WRITE_PH;
            live_slot = find_live_slot();
            if (live_slot >= 0 && $urandom_range(0, 99) < 85) begin
                rq.slot = SLOT_W'(live_slot);
                rq.gen  = gen_table[live_slot];
            end else if (water_mark > 0 && $urandom_range(0, 99) < 70) begin
                rq.slot = SLOT_W'($urandom_range(0, water_mark - 1));
                case ($urandom_range(0, 3))
                    0: rq.gen = '0;
                    1: rq.gen = gen_table[rq.slot] + 1;
                    2: rq.gen = gen_table[rq.slot] - 1;
                    default: rq.gen = gen_table[rq.slot];
                endcase
            end
        end else begin
            rq.opcode = OP_W'($urandom_range(OP_BAD_LO, OP_BAD_HI));
        end
        return rq;
    endfunction

    function automatic void add_cfg(input logic [CAP_W-1:0] cap);
        t_dir_row row;
        row        = '{default: '0};
        row.is_cfg = 1'b1;
        row.cap    = cap;
        dir_table.insert(dir_table.size(), row);
    endfunction

    function automatic void add_op(input logic [OP_W-1:0] op, input int slot,
                                   input logic [GEN_W-1:0] gen, input bit pval);
        t_dir_row row;
        row    = '{default: '0};
        row.rq = '{opcode: op, slot: SLOT_W'(slot), gen: gen, pval: pval};
        dir_table.insert(dir_table.size(), row);
    endfunction

    function automatic void add_typed(input logic [OP_W-1:0] op, input int slot,
                                      input logic [GEN_W-1:0] gen, input bit pval,
                                      input t_status st, input int rslot,
                                      input logic [GEN_W-1:0] rgen, input bit flag,
                                      input int live);
        t_dir_row row;
        row       = '{default: '0};
        row.rq    = '{opcode: op, slot: SLOT_W'(slot), gen: gen, pval: pval};
        row.typed = 1'b1;
        row.want  = '{status: st, slot: SLOT_W'(rslot), gen: rgen, flag: flag,
                      live: COUNT_W'(live)};
        dir_table.insert(dir_table.size(), row);
    endfunction

    function automatic void compare_field(input string field, input logic [GEN_W-1:0] want,
                                          input logic [GEN_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d (0x%0h), got %0d (0x%0h)",
                     $time, field, want, want, got, got);
            mismatch_count++;
        end
    endfunction

    // drive one transaction and wait for acceptance
    task automatic send_request(input t_request rq, input bit typed, input t_outcome want);
        t_outcome predicted;
        req_ch.valid          <= 1'b1;
        req_ch.opcode         <= rq.opcode;
        req_ch.req_slot       <= rq.slot;
        req_ch.req_generation <= rq.gen;
        req_ch.phantom_value  <= rq.pval;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predicted = resolve_request(rq);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
    endtask

    // random sender gap after a transaction
    task automatic idle_gap();
        if ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge i_clk);
        end
    endtask

    // capacity write once every response is back
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cap_reg = value;
        cfg_writes++;
        cfg_we <= 1'b0;
    endtask

    // response side: score and apply random backpressure
    initial begin
        t_outcome want;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected response, expected none, got status %0d slot %0d",
                             $time, rsp_ch.status, rsp_ch.result_slot);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("status", GEN_W'(want.status), GEN_W'(rsp_ch.status));
                    compare_field("result_slot", GEN_W'(want.slot),
                                  GEN_W'(rsp_ch.result_slot));
                    compare_field("result_generation", want.gen, rsp_ch.result_generation);
                    compare_field("phantom_flag", GEN_W'(want.flag),
                                  GEN_W'(rsp_ch.phantom_flag));
                    compare_field("live_total", GEN_W'(want.live),
                                  GEN_W'(rsp_ch.live_total));
                end
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // stimulus
    initial begin
        i_rst_n               = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = '0;
        req_ch.valid          = 1'b0;
        req_ch.opcode         = OP_ALLOC;
        req_ch.req_slot       = '0;
        req_ch.req_generation = '0;
        req_ch.phantom_value  = 1'b0;

        // shadow table reset
        for (int s = 0; s < SLOTS; s++) begin
            gen_table[s]   = '0;
            alive_map[s]   = 1'b0;
            phantom_map[s] = 1'b0;
            free_slots[s]  = '0;
        end
        free_count = 0;
        water_mark = 0;
        live_count = 0;
        cap_reg    = CAP_RESET;

        // empty table: null, extreme and unknown requests
        add_typed(OP_ALIVE, 0, 32'h0, 1'b0, ST_STALE, 0, 32'h0, 1'b0, 0);
        add_typed(OP_RELEASE, 1023, 32'hFFFF_FFFF, 1'b1, ST_STALE, 1023, 32'hFFFF_FFFF,
                  1'b0, 0);
        add_typed(OP_BAD_HI, 1023, 32'hFFFF_FFFF, 1'b1, ST_STALE, 1023, 32'hFFFF_FFFF,
                  1'b0, 0);
        // single-slot cap: full table, phantom flag, release and lifo reuse
        add_cfg(11'd1);
        add_typed(OP_ALLOC, 1023, 32'hFFFF_FFFF, 1'b1, ST_OK, 0, 32'h1, 1'b0, 1);
        add_typed(OP_ALLOC, 0, 32'h0, 1'b0, ST_FULL, 0, 32'h0, 1'b0, 1);
        add_typed(OP_WRITE_PH, 0, 32'h1, 1'b1, ST_OK, 0, 32'h1, 1'b1, 1);
        add_typed(OP_READ_PH, 0, 32'h1, 1'b0, ST_OK, 0, 32'h1, 1'b1, 1);
        add_typed(OP_READ_PH, 0, 32'h2, 1'b0, ST_STALE, 0, 32'h2, 1'b0, 1);
        add_typed(OP_ALIVE, 0, 32'h1, 1'b0, ST_OK, 0, 32'h1, 1'b1, 1);
        add_typed(OP_RELEASE, 0, 32'h1, 1'b0, ST_OK, 0, 32'h1, 1'b1, 0);
        add_typed(OP_RELEASE, 0, 32'h1, 1'b0, ST_STALE, 0, 32'h1, 1'b0, 0);
        add_typed(OP_ALLOC, 0, 32'h0, 1'b0, ST_OK, 0, 32'h2, 1'b0, 1);
        add_typed(OP_READ_PH, 0, 32'h2, 1'b1, ST_OK, 0, 32'h2, 1'b0, 1);
        add_op(OP_WRITE_PH, 0, 32'h2, 1'b0);
        // cap above table size, stack order of released slots
        add_cfg(11'd2047);
        add_op(OP_ALLOC, 0, 32'h0, 1'b0);
        add_op(OP_ALLOC, 0, 32'h0, 1'b0);
        add_op(OP_RELEASE, 1, 32'h1, 1'b0);
        add_op(OP_RELEASE, 2, 32'h1, 1'b0);
        add_op(OP_ALLOC, 0, 32'h0, 1'b0);
        add_op(OP_ALLOC, 0, 32'h0, 1'b0);
        add_op(OP_ALIVE, 3, 32'h1, 1'b0);
        add_op(OP_BAD_LO, 512, 32'h8000_0000, 1'b0);
        add_op(OP_BAD_MID, 341, 32'h5555_5555, 1'b1);
        // zero cap means uncapped
        add_cfg(11'd0);
        add_op(OP_ALLOC, 0, 32'h0, 1'b0);
        add_op(OP_WRITE_PH, 3, 32'h1, 1'b1);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (dir_table[r]) begin
            if (dir_table[r].is_cfg)
                write_capacity(dir_table[r].cap);
            else
                send_request(dir_table[r].rq, dir_table[r].typed, dir_table[r].want);
        end

        // random phases: capacity setting and handshake pressure per phase
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_capacity(11'd40);
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    write_capacity(11'd1024);
                    send_idle_pct  = 82;
                    recv_stall_pct = 0;
                end
                2: begin
                    write_capacity(11'd2047);
                    send_idle_pct  = 0;
                    recv_stall_pct = 82;
                end
                default: begin
                    // cap below the high-water mark: only reused slots
                    write_capacity(11'd8);
                    send_idle_pct  = 20;
                    recv_stall_pct = 20;
                end
            endcase
            repeat (PHASE_ITEMS) begin
                send_request(random_request(), 1'b0, '0);
                idle_gap();
            end
        end

        // drain
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("run covered %0d requests: %0d allocations, %0d table-full, %0d stale",
                 request_count, alloc_total, full_total, stale_total);
        $display("%0d capacity writes, four backpressure patterns, %0d mismatches",
                 cfg_writes, mismatch_count);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
